[design/lkv_pkg.sv]
// lkv_pkg: shared constants, types and state encoding for the lru key-value cache
// used by lkv_ctrl, lkv_dp and the top level lru_key_value_cache_core
// no dependencies
package lkv_pkg;

	localparam int ENTRIES = 16;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CAP_W   = 5;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;

	localparam int IN_DATA_W  = ((KEY_W + VAL_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((VAL_W + 7) / 8) * 8;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// which slot a touch or write goes to
	typedef enum logic [1:0] {
		SEL_HIT,
		SEL_LRU,
		SEL_FREE
	} lkv_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_RESULT
	} lkv_state_t;

	typedef struct packed {
		logic     load;
		logic     scan;
		logic     val_rd;
		logic     touch;
		logic     wr_key;
		logic     wr_val;
		logic     insert;
		logic     out_load;
		lkv_sel_t sel;
	} lkv_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic is_put;
		logic found;
		logic full;
		logic out_free;
	} lkv_sts_t;

endpackage

[design/lkv_ram.sv]
// lkv_ram: generic single write port ram with one registered read port
// no dependencies
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic                                          re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/lkv_dp.sv]
// lkv_dp: datapath of the lru cache: key/value rams, valid bits, recency ranks,
// key scan, touch update, capacity register and output register
// depends on lkv_pkg and lkv_ram
module lkv_dp import lkv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  lkv_cmd_t         c,
	output lkv_sts_t         st,
	input  logic             in_put,
	input  logic [KEY_W-1:0] in_key,
	input  logic [VAL_W-1:0] in_value,
	input  logic             cfg_wr,
	input  logic [CAP_W-1:0] cfg_data,
	output logic             out_valid,
	output logic             out_hit,
	output logic [VAL_W-1:0] out_value,
	input  logic             out_ready
);

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic             put_q;
	logic [CAP_W-1:0] cap_q;

	logic [CNT_W-1:0] scan_idx_q;
	logic             chk_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             scan_issue;

	logic             found_q;
	logic [IDX_W-1:0] slot_q;
	logic [IDX_W-1:0] hit_rank_q;
	logic             lru_found_q;
	logic [IDX_W-1:0] lru_slot_q;
	logic [IDX_W-1:0] lru_rank_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_slot_q;

	logic [ENTRIES-1:0] valid_q;
	logic [IDX_W-1:0]   rank_q [ENTRIES];
	logic [CNT_W-1:0]   count_q;

	logic [KEY_W-1:0] key_rd;
	logic [VAL_W-1:0] val_rd;
	logic             cur_valid;
	logic [IDX_W-1:0] cur_rank;
	logic             key_match;

	logic [IDX_W-1:0] tgt;
	logic [CNT_W-1:0] old_rank;
	logic [CMP_W-1:0] eff_cap;

	logic             out_valid_q;
	logic             out_hit_q;
	logic [VAL_W-1:0] out_value_q;
	logic             out_free;

	// one key per cycle
	assign scan_issue = c.scan && (scan_idx_q != CNT_W'(ENTRIES));

	lkv_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (c.wr_key),
		.waddr (tgt),
		.wdata (key_q),
		.re    (scan_issue),
		.raddr (scan_idx_q[IDX_W-1:0]),
		.rdata (key_rd)
	);

	lkv_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (c.wr_val),
		.waddr (tgt),
		.wdata (value_q),
		.re    (c.val_rd),
		.raddr (slot_q),
		.rdata (val_rd)
	);

	always_ff @(posedge clk) begin
		if (c.load) begin
			key_q   <= in_key;
			value_q <= in_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			put_q <= 1'b0;
			cap_q <= CAP_RESET;
		end else begin
			if (c.load) begin
				put_q <= in_put;
			end
			if (cfg_wr) begin
				cap_q <= cfg_data;
			end
		end
	end

	// scan pipeline: address then compare against the registered ram data
	assign cur_valid = valid_q[idx_s1];
	assign cur_rank  = rank_q[idx_s1];
	assign key_match = chk_s1 && cur_valid && (key_rd == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			chk_s1       <= 1'b0;
			idx_s1       <= '0;
			found_q      <= 1'b0;
			lru_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (c.load) begin
			scan_idx_q   <= '0;
			chk_s1       <= 1'b0;
			found_q      <= 1'b0;
			lru_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			chk_s1 <= scan_issue;
			if (scan_issue) begin
				idx_s1     <= scan_idx_q[IDX_W-1:0];
				scan_idx_q <= scan_idx_q + 1'b1;
			end
			if (key_match && !found_q) begin
				found_q <= 1'b1;
			end
			if (chk_s1 && cur_valid && (!lru_found_q || (cur_rank > lru_rank_q))) begin
				lru_found_q <= 1'b1;
			end
			if (chk_s1 && !cur_valid && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (key_match && !found_q) begin
			slot_q     <= idx_s1;
			hit_rank_q <= cur_rank;
		end
		if (chk_s1 && cur_valid && (!lru_found_q || (cur_rank > lru_rank_q))) begin
			lru_slot_q <= idx_s1;
			lru_rank_q <= cur_rank;
		end
		if (chk_s1 && !cur_valid && !free_found_q) begin
			free_slot_q <= idx_s1;
		end
	end

	// target slot and the rank that entries below it age past
	always_comb begin
		unique case (c.sel)
			SEL_HIT: begin
				tgt      = slot_q;
				old_rank = CNT_W'(hit_rank_q);
			end
			SEL_LRU: begin
				tgt      = lru_slot_q;
				old_rank = CNT_W'(lru_rank_q);
			end
			SEL_FREE: begin
				tgt      = free_slot_q;
				old_rank = count_q + 1'b1;
			end
			default: begin
				tgt      = free_slot_q;
				old_rank = count_q + 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (c.touch) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (IDX_W'(i) == tgt) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (CNT_W'(rank_q[i]) < old_rank)) begin
						rank_q[i] <= rank_q[i] + 1'b1;
					end
				end
			end
			if (c.insert) begin
				valid_q[tgt] <= 1'b1;
				count_q      <= count_q + 1'b1;
			end
		end
	end

	// capacity 0 acts as 1, above the entry count as the entry count
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = CMP_W'(cap_q);
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (c.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (c.out_load) begin
			out_hit_q   <= found_q;
			out_value_q <= found_q ? val_rd : '0;
		end
	end

	assign st.scan_done = chk_s1 && (idx_s1 == IDX_W'(ENTRIES - 1));
	assign st.is_put    = put_q;
	assign st.found     = found_q;
	assign st.full      = CMP_W'(count_q) >= eff_cap;
	assign st.out_free  = out_free;

	assign out_valid = out_valid_q;
	assign out_hit   = out_hit_q;
	assign out_value = out_value_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ENTRIES))
		else $error("entry count above entry total");

	a_no_touch_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		!(c.touch && scan_issue))
		else $error("rank update during key scan");

	a_insert_valid: assert property (@(posedge clk) disable iff (!arst_n)
		c.insert |=> valid_q[$past(tgt)])
		else $error("inserted slot not marked valid");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		c.out_load |-> out_free)
		else $error("result overwrites an untaken result");

endmodule

[design/lkv_ctrl.sv]
// lkv_ctrl: controller state machine of the lru cache, sequences scan, decision,
// update and result hand-off through command and status structs
// depends on lkv_pkg
module lkv_ctrl import lkv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  lkv_sts_t st,
	output lkv_cmd_t c
);

	lkv_state_t state_q;
	lkv_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		c        = '0;
		c.sel    = SEL_HIT;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					c.load  = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				c.scan = 1'b1;
				if (st.scan_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (!st.is_put) begin
					if (st.found) begin
						c.val_rd = 1'b1;
						c.touch  = 1'b1;
						c.sel    = SEL_HIT;
					end
					state_d = ST_RESULT;
				end else begin
					c.touch  = 1'b1;
					c.wr_val = 1'b1;
					if (st.found) begin
						c.sel = SEL_HIT;
					end else if (st.full) begin
						c.wr_key = 1'b1;
						c.sel    = SEL_LRU;
					end else begin
						c.wr_key = 1'b1;
						c.insert = 1'b1;
						c.sel    = SEL_FREE;
					end
					state_d = ST_IDLE;
				end
			end
			ST_RESULT: begin
				if (st.out_free) begin
					c.out_load = 1'b1;
					state_d    = ST_IDLE;
				end
			end
		endcase
	end

endmodule

[design/lru_key_value_cache_core.sv]
// lru_key_value_cache_core: top level of a fully associative key-value cache
// with least recently used replacement, joins controller and datapath
// depends on lkv_pkg, lkv_ctrl, lkv_dp (and lkv_ram through lkv_dp)
//
//  group  dir  signals                         item
//  s_*    in   tvalid tready tdata tuser       one get or put request
//  m_*    out  tvalid tready tdata tuser       one get result (puts give none)
//  cfg_*  in   valid ready data                capacity register write
//
// a request passes the idle state that takes the item, a scan of all keys
// through the registered key ram read, the decide state and, for a get, the
// result state that loads the result register
// reset clears valid bits, ranks, entry count and sets capacity to 16; key and
// value rams are not cleared, the scan ignores the keys of invalid slots
// a waiting result does not block the next request; only a later get waits
// in its result state until the output register is free
module lru_key_value_cache_core import lkv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// s_tdata: key [31:0], write_value [63:32]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: cmd (0 get, 1 put)
	input  logic                  s_tuser,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// m_tdata: read_value [31:0], zero on a miss
	output logic [OUT_DATA_W-1:0] m_tdata,
	// m_tuser: hit
	output logic                  m_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [CAP_W-1:0]      cfg_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready
);

	lkv_cmd_t         cmd;
	lkv_sts_t         sts;
	logic [VAL_W-1:0] rd_value;

	// capacity write is always taken
	assign cfg_ready = 1'b1;

	lkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (sts),
		.c        (cmd)
	);

	lkv_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.c         (cmd),
		.st        (sts),
		.in_put    (s_tuser),
		.in_key    (s_tdata[KEY_W-1:0]),
		.in_value  (s_tdata[KEY_W+VAL_W-1:KEY_W]),
		.cfg_wr    (cfg_valid),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_hit   (m_tuser),
		.out_value (rd_value),
		.out_ready (m_tready)
	);

	assign m_tdata = OUT_DATA_W'(rd_value);

endmodule
